// ===== design/htpid_pkg.sv =====
// Package: shared types, constants and the calibration table of the heater PID block.
`default_nettype none
package htpid_pkg;

  localparam int ADC_BITS   = 12;
  localparam int TEMP_W     = 15;
  localparam int DUTY_W     = 15;
  localparam int TGT_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 8;
  localparam int TOL_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CAL_DEG_W  = 9;
  localparam int FRAC_W     = 6;
  localparam int ERR_W      = 17;
  localparam int DERR_W     = 18;
  localparam int PROD_W     = GAIN_W + 1 + DERR_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int INTEG_W    = 17;
  localparam int PREV_W     = 16;
  localparam int Q_W        = TEMP_W;
  localparam int NUM_W      = ADC_BITS + CAL_DEG_W + FRAC_W;
  localparam int DUTY_MAX   = 25600;
  localparam int CAL_ROWS   = 14;

  typedef struct packed {
    logic                sensor_sel;
    logic [ADC_BITS-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              target_reached;
    logic [DUTY_W-1:0] heater_duty;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXT_TGT = 3'd0,
    CFG_BED_TGT = 3'd1,
    CFG_GAIN_P  = 3'd2,
    CFG_GAIN_I  = 3'd3,
    CFG_GAIN_D  = 3'd4,
    CFG_ILIM    = 3'd5,
    CFG_TOL     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT, ST_SRCH, ST_DMUL, ST_DGO, ST_DWAIT, ST_TEMP,
    ST_ERR, ST_MP, ST_MI, ST_MD, ST_SUM, ST_FLAG, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FILT, OP_SRCH, OP_DMUL, OP_DGO, OP_DWAIT, OP_TEMP,
    OP_ERR, OP_MP, OP_MI, OP_MD, OP_SUM, OP_FLAG, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_hit;    // clamped below first or at/above last row
    logic srch_found;  // segment located
    logic div_done;
    logic is_ext;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]  adc_ext;
    logic [ADC_BITS-1:0]  adc_bed;
    logic [CAL_DEG_W-1:0] deg;
  } cal_row_t;

  // default thermistor table; rows past the end repeat the last one
  function automatic cal_row_t calib_row(input int unsigned r);
    cal_row_t row;
    case (r)
      0:       row = '{12'd860,  12'd60,   9'd300};
      1:       row = '{12'd1849, 12'd95,   9'd248};
      2:       row = '{12'd2208, 12'd119,  9'd226};
      3:       row = '{12'd2711, 12'd215,  9'd198};
      4:       row = '{12'd2960, 12'd293,  9'd183};
      5:       row = '{12'd3332, 12'd447,  9'd163};
      6:       row = '{12'd3568, 12'd641,  9'd145};
      7:       row = '{12'd3711, 12'd865,  9'd131};
      8:       row = '{12'd3870, 12'd1408, 9'd105};
      9:       row = '{12'd3960, 12'd1906, 9'd86};
      10:      row = '{12'd4032, 12'd2732, 9'd64};
      11:      row = '{12'd4062, 12'd3352, 9'd42};
      12:      row = '{12'd4070, 12'd3755, 9'd22};
      default: row = '{12'd4080, 12'd4085, 9'd0};
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

// ===== design/htpid_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit Q_W bits.
`default_nettype none
module htpid_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [htpid_pkg::NUM_W-1:0]  num_i,
  input  wire logic [htpid_pkg::ADC_BITS-1:0] den_i,
  output logic                              done_o,
  output logic [htpid_pkg::Q_W-1:0]         quot_o
);
  import htpid_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [ADC_BITS-1:0] rem_q, rem_d;
  logic [Q_W-1:0]      low_q, low_d, quot_q, quot_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [ADC_BITS:0]   rem_sh, rem_sub;
  logic                qbit;

  always_comb begin
    rem_sh  = {rem_q, low_q[Q_W-1]};
    rem_sub = rem_sh - {1'b0, den_i};
    qbit    = rem_sh >= {1'b0, den_i};
  end

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i[NUM_W-1:Q_W];
      low_d  = num_i[Q_W-1:0];
      cnt_d  = CNT_W'(Q_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? rem_sub[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
      low_d  = {low_q[Q_W-2:0], 1'b0};
      quot_d = {quot_q[Q_W-2:0], qbit};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

// ===== design/htpid_ctrl.sv =====
// Sequencer: steps one item through filter, table search, divide, PID and flag.
`default_nettype none
module htpid_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire htpid_pkg::dp_status_t   status_i,
  output htpid_pkg::dp_cmd_t           cmd_o
);
  import htpid_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_FILT;
      ST_FILT:  state_d = ST_SRCH;
      ST_SRCH: begin
        if (status_i.srch_hit) state_d = status_i.is_ext ? ST_ERR : ST_FLAG;
        else if (status_i.srch_found) state_d = ST_DMUL;
      end
      ST_DMUL:  state_d = ST_DGO;
      ST_DGO:   state_d = ST_DWAIT;
      ST_DWAIT: if (status_i.div_done) state_d = ST_TEMP;
      ST_TEMP:  state_d = status_i.is_ext ? ST_ERR : ST_FLAG;
      ST_ERR:   state_d = ST_MP;
      ST_MP:    state_d = ST_MI;
      ST_MI:    state_d = ST_MD;
      ST_MD:    state_d = ST_SUM;
      ST_SUM:   state_d = ST_FLAG;
      ST_FLAG:  state_d = ST_OUT;
      ST_OUT:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_FILT:  cmd_o.op = OP_FILT;
      ST_SRCH:  cmd_o.op = OP_SRCH;
      ST_DMUL:  cmd_o.op = OP_DMUL;
      ST_DGO:   cmd_o.op = OP_DGO;
      ST_DWAIT: cmd_o.op = OP_DWAIT;
      ST_TEMP:  cmd_o.op = OP_TEMP;
      ST_ERR:   cmd_o.op = OP_ERR;
      ST_MP:    cmd_o.op = OP_MP;
      ST_MI:    cmd_o.op = OP_MI;
      ST_MD:    cmd_o.op = OP_MD;
      ST_SUM:   cmd_o.op = OP_SUM;
      ST_FLAG:  cmd_o.op = OP_FLAG;
      ST_OUT:   cmd_o.op = OP_OUT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/htpid_dp.sv =====
// Datapath: config registers, filters, table interpolation, PID and output register.
`default_nettype none
module htpid_dp #(
  parameter int TABLE_ROWS   = 14,
  parameter int SENSOR_COUNT = 2
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire htpid_pkg::dp_cmd_t               cmd_i,
  output htpid_pkg::dp_status_t                 status_o,
  input  wire htpid_pkg::in_item_t              in_item_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output htpid_pkg::out_item_t                  out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [htpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [htpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import htpid_pkg::*;

  localparam int IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int FI_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  // configuration
  logic [TGT_W-1:0]  ext_tgt_q, bed_tgt_q;
  logic [GAIN_W-1:0] gp_q, gi_q, gd_q;
  logic [ILIM_W-1:0] ilim_q;
  logic [TOL_W-1:0]  tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_tgt_q <= '0;
      bed_tgt_q <= '0;
      gp_q      <= '0;
      gi_q      <= '0;
      gd_q      <= '0;
      ilim_q    <= ILIM_W'(100);
      tol_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXT_TGT: ext_tgt_q <= cfg_data_i[TGT_W-1:0];
        CFG_BED_TGT: bed_tgt_q <= cfg_data_i[TGT_W-1:0];
        CFG_GAIN_P:  gp_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:  gi_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:  gd_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_ILIM:    ilim_q    <= cfg_data_i[ILIM_W-1:0];
        CFG_TOL:     tol_q     <= cfg_data_i[TOL_W-1:0];
        default:     ;
      endcase
    end
  end

  // item capture and per-sensor filter
  logic                sel_q;
  logic [ADC_BITS-1:0] raw_q, fv_q;
  logic [ADC_BITS-1:0] filt_q [SENSOR_COUNT];
  logic [FI_W-1:0]     fi;
  logic [ADC_BITS+3:0] fsum;

  always_comb begin
    if (SENSOR_COUNT > 1 && 32'(sel_q) < SENSOR_COUNT) fi = FI_W'(sel_q);
    else fi = FI_W'(SENSOR_COUNT - 1);
    fsum = {filt_q[fi], 4'b0} - {4'b0, filt_q[fi]} + {4'b0, raw_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSOR_COUNT; s++) filt_q[s] <= '1;
    end else if (cmd_i.op == OP_FILT) begin
      filt_q[fi] <= fsum[ADC_BITS+3:4];
    end
  end

  // table search over rows, one row a cycle
  logic [IDX_W-1:0]     idx_q;
  cal_row_t             row_cur, row_prev, row_first, row_last;
  logic [ADC_BITS-1:0]  adc_cur, adc_prev, adc_first, adc_last;
  logic                 lo_clamp, hi_clamp;
  logic [ADC_BITS-1:0]  a0_q, a1_q;
  logic [CAL_DEG_W-1:0] t0_q, t1_q;

  always_comb begin
    row_cur   = calib_row(32'(idx_q));
    row_prev  = calib_row(32'(idx_q - IDX_W'(1)));
    row_first = calib_row(0);
    row_last  = calib_row(32'(TABLE_ROWS - 1));
    adc_cur   = sel_q ? row_cur.adc_bed   : row_cur.adc_ext;
    adc_prev  = sel_q ? row_prev.adc_bed  : row_prev.adc_ext;
    adc_first = sel_q ? row_first.adc_bed : row_first.adc_ext;
    adc_last  = sel_q ? row_last.adc_bed  : row_last.adc_ext;
    lo_clamp  = fv_q < adc_first;
    hi_clamp  = fv_q >= adc_last;
  end

  // interpolation
  logic [NUM_W-1:0]     num_q;
  logic [ADC_BITS-1:0]  den_q, span;
  logic [CAL_DEG_W-1:0] dt;
  logic                 inc_q, flat_q;
  logic                 div_done;
  logic [Q_W-1:0]       quot;
  logic [TEMP_W-1:0]    temp_q, base;

  always_comb begin
    span = fv_q - a0_q;
    dt   = (t1_q >= t0_q) ? t1_q - t0_q : t0_q - t1_q;
    base = {t0_q, {FRAC_W{1'b0}}};
  end

  htpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_DGO),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // PID
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [DERR_W-1:0] derr_q, derr_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  p_q, it_sum, o_sum, it_clamp, o_clamp;
  logic [INTEG_W-1:0]       it_q, integ_q;
  logic signed [PREV_W-1:0] prev_q;
  logic [DUTY_W-1:0]        duty_q;
  logic [GAIN_W-1:0]        mul_gain;
  logic signed [DERR_W-1:0] mul_val;
  logic signed [ACC_W-1:0]  prod_sc, ilim_ext;

  always_comb begin
    err_d  = $signed({2'b0, ext_tgt_q}) - $signed({2'b0, temp_q});
    derr_d = DERR_W'(err_q) - DERR_W'(prev_q);
    case (cmd_i.op)
      OP_MI:   begin mul_gain = gi_q; mul_val = DERR_W'(err_q); end
      OP_MD:   begin mul_gain = gd_q; mul_val = derr_q;         end
      default: begin mul_gain = gp_q; mul_val = DERR_W'(err_q); end
    endcase
    prod_d   = PROD_W'($signed({1'b0, mul_gain})) * PROD_W'(mul_val);
    prod_sc  = ACC_W'(prod_q >>> FRAC_W);
    ilim_ext = $signed({{(ACC_W-ILIM_W-8){1'b0}}, ilim_q, 8'b0});
    it_sum   = $signed({{(ACC_W-INTEG_W){1'b0}}, integ_q}) + prod_sc;
    if (it_sum > ilim_ext) it_clamp = ilim_ext;
    else if (it_sum < 0) it_clamp = '0;
    else it_clamp = it_sum;
    o_sum = p_q + $signed({{(ACC_W-INTEG_W){1'b0}}, it_q}) + prod_sc;
    if (o_sum > ACC_W'(DUTY_MAX)) o_clamp = ACC_W'(DUTY_MAX);
    else if (o_sum < 0) o_clamp = '0;
    else o_clamp = o_sum;
  end

  // target flag
  logic [TEMP_W+6:0]       lhs_q;
  logic signed [TGT_W+8:0] rhs_q;
  logic [TGT_W-1:0]        tgt_sel;
  logic signed [7:0]       tol_fac;
  logic                    reached;
  logic                    out_valid_q, out_free;
  out_item_t               out_q;

  always_comb begin
    tgt_sel  = sel_q ? bed_tgt_q : ext_tgt_q;
    tol_fac  = 8'sd100 - $signed({1'b0, tol_q});
    reached  = $signed({2'b0, lhs_q}) >= $signed({rhs_q[TGT_W+8], rhs_q});
    out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_q      <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SUM) begin
        prev_q <= err_q[PREV_W-1:0];
        if (ext_tgt_q == '0) begin
          integ_q <= '0;
          duty_q  <= '0;
        end else begin
          integ_q <= it_q;
          duty_q  <= o_clamp[DUTY_W-1:0];
        end
      end
      if (cmd_i.op == OP_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sel_q <= in_item_i.sensor_sel;
        raw_q <= in_item_i.adc_sample;
      end
      OP_FILT: begin
        fv_q  <= fsum[ADC_BITS+3:4];
        idx_q <= '0;
      end
      OP_SRCH: begin
        if (idx_q == '0) begin
          if (lo_clamp) temp_q <= {row_first.deg, {FRAC_W{1'b0}}};
          else if (hi_clamp) temp_q <= {row_last.deg, {FRAC_W{1'b0}}};
          idx_q <= IDX_W'(1);
        end else if (fv_q < adc_cur) begin
          a0_q <= adc_prev;
          a1_q <= adc_cur;
          t0_q <= row_prev.deg;
          t1_q <= row_cur.deg;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      OP_DMUL: begin
        num_q  <= (NUM_W'(span) * NUM_W'(dt)) << FRAC_W;
        den_q  <= a1_q - a0_q;
        inc_q  <= t1_q >= t0_q;
        flat_q <= (a1_q <= a0_q) || (fv_q < a0_q);
      end
      OP_TEMP: begin
        if (flat_q) temp_q <= base;
        else if (inc_q) temp_q <= base + quot;
        else temp_q <= base - quot;
      end
      OP_ERR: begin
        err_q <= err_d;
      end
      OP_MP: begin
        derr_q <= derr_d;
        prod_q <= prod_d;
      end
      OP_MI: begin
        p_q    <= prod_sc;
        prod_q <= prod_d;
      end
      OP_MD: begin
        it_q   <= it_clamp[INTEG_W-1:0];
        prod_q <= prod_d;
      end
      OP_FLAG: begin
        lhs_q <= (TEMP_W+7)'(temp_q) * (TEMP_W+7)'(7'd100);
        rhs_q <= (TGT_W+9)'($signed({1'b0, tgt_sel})) * (TGT_W+9)'(tol_fac);
      end
      OP_OUT: begin
        if (out_free) begin
          out_q.temperature    <= temp_q;
          out_q.target_reached <= reached;
          out_q.heater_duty    <= duty_q;
        end
      end
      default: ;
    endcase
  end

  assign status_o.srch_hit   = (cmd_i.op == OP_SRCH) && (idx_q == '0) && (lo_clamp || hi_clamp);
  assign status_o.srch_found = (cmd_i.op == OP_SRCH) && (idx_q != '0) && (fv_q < adc_cur);
  assign status_o.div_done   = div_done;
  assign status_o.is_ext     = !sel_q;
  assign status_o.out_free   = out_free;
  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;
endmodule
`default_nettype wire

// ===== design/heater_temperature_pid_controller.sv =====
// Top level: heater thermistor conversion and extruder PID controller.
`default_nettype none
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_ready   in_item_t  {sensor_sel, adc_sample}
// out      out  out_valid/out_ready out_item_t {temperature, target_reached, heater_duty}
// cfg      in   cfg_we (no wait)    cfg_idx, cfg_data (16 bit)
//
// One item at a time. An item passes accept, filter and table search, then interpolation
// when a segment is found, PID for an extruder item, then flag and output. The table search
// walks one row a cycle; an interpolated segment uses the shared restoring divider, and an
// extruder item steps through error, P, I, D and sum of PID with one multiplier.
// Reset is asynchronous, active low; filters come up at full scale, PID state at zero.
// The output register holds a result until taken; the next item is accepted meanwhile,
// and only the final load waits for the output register to free up.
module heater_temperature_pid_controller #(
  parameter int TABLE_ROWS   = 14,
  parameter int SENSOR_COUNT = 2
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire htpid_pkg::in_item_t              in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output htpid_pkg::out_item_t                  out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [htpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [htpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import htpid_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  htpid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath with config registers and output register
  htpid_dp #(
    .TABLE_ROWS   (TABLE_ROWS),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // an accepted item keeps the port closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while an item is in work");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> cmd.op == OP_DWAIT)
    else $error("divider result outside its wait step");

  // duty never leaves its clamp range
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.heater_duty <= DUTY_W'(DUTY_MAX))
    else $error("heater duty above full scale");
endmodule
`default_nettype wire

// ===== bench/heater_temperature_pid_checker.sv =====
// Checker: watches the item channels, predicts each reading and compares it.
`timescale 1ns / 1ps
module heater_temperature_pid_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_ready_i,
  input  wire htpid_pkg::in_item_t              in_item_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_ready_i,
  input  wire htpid_pkg::out_item_t             out_item_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [htpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [htpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    readings_o
);
  import htpid_pkg::*;

  localparam int ROWS = 14;
  localparam int unsigned ROW_EXT[ROWS] = '{860, 1849, 2208, 2711, 2960, 3332, 3568,
                                            3711, 3870, 3960, 4032, 4062, 4070, 4080};
  localparam int unsigned ROW_BED[ROWS] = '{60, 95, 119, 215, 293, 447, 641,
                                            865, 1408, 1906, 2732, 3352, 3755, 4085};
  localparam int unsigned ROW_DEG[ROWS] = '{300, 248, 226, 198, 183, 163, 145,
                                            131, 105, 86, 64, 42, 22, 0};

  // shadow registers and controller state
  longint ext_tgt, bed_tgt, kp, ki, kd, ilim, tol;
  longint filt [2];
  longint integ, prev_err, duty_hold;
  out_item_t expected_readings[$];

  function automatic longint floor_q6(longint v);
    return (v >= 0) ? v / 64 : -((-v + 63) / 64);
  endfunction

  function automatic longint lookup_degrees(longint f, bit bed);
    longint a0, a1, t0, t1;
    a0 = bed ? ROW_BED[0] : ROW_EXT[0];
    if (f < a0) return ROW_DEG[0] * 64;
    a1 = bed ? ROW_BED[ROWS-1] : ROW_EXT[ROWS-1];
    if (f >= a1) return ROW_DEG[ROWS-1] * 64;
    for (int i = 1; i < ROWS; i++) begin
      a1 = bed ? ROW_BED[i] : ROW_EXT[i];
      if (f < a1) begin
        a0 = bed ? ROW_BED[i-1] : ROW_EXT[i-1];
        t0 = ROW_DEG[i-1];
        t1 = ROW_DEG[i];
        if (f < a0 || a1 <= a0) return t0 * 64;   // empty segment
        if (t1 >= t0) return t0 * 64 + ((f - a0) * (t1 - t0) * 64) / (a1 - a0);
        return t0 * 64 - ((f - a0) * (t0 - t1) * 64) / (a1 - a0);
      end
    end
    return 0;
  endfunction

  function automatic out_item_t predict_reading(in_item_t it);
    out_item_t r;
    longint temp, tgt, err, p, d, acc, o;
    int s;
    s = it.sensor_sel;
    filt[s] = ((filt[s] * 15 + it.adc_sample) / 16) & 12'hFFF;
    temp = lookup_degrees(filt[s], it.sensor_sel) & 15'h7FFF;
    tgt = s ? bed_tgt : ext_tgt;
    if (s == 0) begin
      err = ext_tgt - temp;
      p = floor_q6(kp * err);
      d = floor_q6(kd * (err - prev_err));
      acc = integ + floor_q6(ki * err);
      if (acc > ilim * 256) acc = ilim * 256;
      if (acc < 0) acc = 0;
      o = p + acc + d;
      if (o > DUTY_MAX) o = DUTY_MAX;
      if (o < 0) o = 0;
      prev_err = err;
      if (ext_tgt == 0) begin
        o = 0;
        acc = 0;
      end
      integ = acc;
      duty_hold = o;
    end
    r.temperature = temp[TEMP_W-1:0];
    r.target_reached = (temp * 100 >= tgt * (100 - tol));
    r.heater_duty = duty_hold[DUTY_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_tgt = 0; bed_tgt = 0; kp = 0; ki = 0; kd = 0; ilim = 100; tol = 0;
      filt[0] = 4095; filt[1] = 4095;
      integ = 0; prev_err = 0; duty_hold = 0;
      fail_count_o <= 0;
      readings_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_EXT_TGT: ext_tgt = cfg_data_i & 16'h7FFF;
          CFG_BED_TGT: bed_tgt = cfg_data_i & 16'h7FFF;
          CFG_GAIN_P:  kp = cfg_data_i;
          CFG_GAIN_I:  ki = cfg_data_i;
          CFG_GAIN_D:  kd = cfg_data_i;
          CFG_ILIM:    ilim = cfg_data_i & 16'hFF;
          CFG_TOL:     tol = cfg_data_i & 16'h7F;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_readings.push_back(predict_reading(in_item_i));
      if (out_valid_i && out_ready_i) begin
        readings_o <= readings_o + 1;
        if (expected_readings.size() == 0) begin
          $error("reading with nothing expected: %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          out_item_t e;
          int bad;
          e = expected_readings.pop_front();
          bad = 0;
          if (e.temperature !== out_item_i.temperature) begin
            $error("temperature: expected %0d, got %0d", e.temperature,
                   out_item_i.temperature);
            bad++;
          end
          if (e.target_reached !== out_item_i.target_reached) begin
            $error("target_reached: expected %0d, got %0d", e.target_reached,
                   out_item_i.target_reached);
            bad++;
          end
          if (e.heater_duty !== out_item_i.heater_duty) begin
            $error("heater_duty: expected %0d, got %0d", e.heater_duty,
                   out_item_i.heater_duty);
            bad++;
          end
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

  assign pending_o = expected_readings.size();

endmodule

// ===== bench/tb_heater_temperature_pid_controller.sv =====
// Testbench top: sample stimulus, register settings, flow control and verdict.
`timescale 1ns / 1ps
module tb_heater_temperature_pid_controller;
  import htpid_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready;
  in_item_t in_item;
  logic out_valid, out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, readings;

  // flow control knobs, percent of cycles spent idling
  int snd_idle, rcv_idle;
  bit hold_req;
  int sent;
  int level [2];     // slowly drifting sample level per sensor

  heater_temperature_pid_controller u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  heater_temperature_pid_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .readings_o(readings)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous watchdog
  initial begin
    #8ms;
    $display("heater_temperature_pid_controller: mismatch");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // offer one item; valid stays up across back-to-back items
  task automatic send_item(input bit sel, input logic [ADC_BITS-1:0] adc);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{sensor_sel: sel, adc_sample: adc};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // settle the block before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_settings(input int ext, input int bed, input int p, input int i,
                                input int d, input int lim, input int tl);
    int v [7];
    v = '{ext, bed, p, i, d, lim, tl};
    for (int k = 0; k < 7; k++) begin
      cfg_we <= 1'b1;
      cfg_idx <= cfg_idx_e'(k);
      cfg_data <= CFG_DATA_W'(v[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly samples near a drifting level so the filter settles; some wild ones
  task automatic random_items(input int n);
    bit sel;
    int x;
    for (int k = 0; k < n; k++) begin
      sel = 1'($urandom_range(1));
      if ($urandom_range(99) < 5) level[sel] = $urandom_range(4095);
      else level[sel] = level[sel] + $urandom_range(80) - 40;
      if (level[sel] < 0) level[sel] = 0;
      if (level[sel] > 4095) level[sel] = 4095;
      x = ($urandom_range(99) < 80) ? level[sel] : $urandom_range(4095);
      send_item(sel, x[ADC_BITS-1:0]);
    end
  endtask

  task automatic random_settings();
    write_settings($urandom_range(19200), $urandom_range(19200), $urandom_range(4096),
                   $urandom_range(1024), $urandom_range(8192), $urandom_range(255),
                   $urandom_range(127));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    snd_idle = 38;
    rcv_idle = 86;
    hold_req = 1'b0;
    sent = 0;
    level[0] = 3000;
    level[1] = 1000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings (zero target holds the heater off), then extremes
    send_item(1'b0, 12'hFFF);
    send_item(1'b1, 12'hFFF);
    send_item(1'b0, 12'h000);
    send_item(1'b1, 12'h000);
    drain();
    write_settings(19200, 19200, 65535, 65535, 65535, 255, 127);
    for (int k = 0; k < 6; k++) send_item(1'b0, 12'h000);   // drive toward hot end
    send_item(1'b1, 12'd50);                                 // below first bed row
    send_item(1'b0, 12'hFFF);
    drain();
    write_settings(12800, 3200, 1024, 256, 2048, 0, 100);
    for (int k = 0; k < 5; k++) send_item(1'b0, 12'd3700);
    send_item(1'b1, 12'd4085);
    send_item(1'b1, 12'hFFF);                                // at/above last row
    send_item(1'b0, 12'h555);
    send_item(1'b0, 12'hAAA);
    drain();
    write_settings(0, 0, 0, 0, 0, 0, 0);
    send_item(1'b0, 12'd2000);
    send_item(1'b1, 12'd2000);

    // phase one: slow sender, slower receiver
    for (int s = 0; s < 2; s++) begin
      drain();
      random_settings();
      random_items(200);
    end
    // phase two: roles swapped
    snd_idle = 86;
    rcv_idle = 38;
    for (int s = 0; s < 2; s++) begin
      drain();
      random_settings();
      random_items(200);
    end
    // phase three: full rate, with one long receiver hold-off
    snd_idle = 0;
    rcv_idle = 0;
    drain();
    write_settings(16000, 5000, 2048, 128, 4096, 100, 10);
    hold_req = 1'b1;
    random_items(220);
    drain();
    random_settings();
    random_items(200);
    drain();
    write_settings(19200, 19200, 65535, 65535, 65535, 255, 0);
    random_items(10);

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d sensor items and %0d readings over reset values and ten loads,",
             sent, readings);
    $display("with idle sender/receiver mixes and one long output stall.");
    if (fail_count == 0 && pending == 0)
      $display("heater_temperature_pid_controller: match");
    else
      $display("heater_temperature_pid_controller: mismatch");
    $finish;
  end

endmodule
